[sv/fiv_pkg.sv]
// Shared types, codes and the CRC-32 byte update for the image verifier.
package fiv_pkg;

  localparam int unsigned IMG_W = 24;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CNT_W = 17;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [31:0]      CRC_POLY = 32'hEDB88320;
  localparam logic [31:0]      CRC_INIT = 32'hFFFFFFFF;
  localparam logic [23:0]      PART_RST = 24'hFFFFFF;
  localparam logic [15:0]      TMO_RST  = 16'd10000;
  localparam logic [6:0]       PCT_MAX  = 7'd100;

  typedef enum logic {
    CFG_PARTITION = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOWN = 2'd1,
    ST_DONE = 2'd2,
    ST_ERR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STARTED  = 3'd1,
    EV_REJECTED = 3'd2,
    EV_CHUNK_OK = 3'd3,
    EV_ABORTED  = 3'd4,
    EV_COMPLETE = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    CS_NONE     = 3'd0,
    CS_BUSY     = 3'd1,
    CS_BATTERY  = 3'd2,
    CS_TOO_BIG  = 3'd3,
    CS_TIMEOUT  = 3'd4,
    CS_SIZE     = 3'd5,
    CS_CRC      = 3'd6,
    CS_NOT_DOWN = 3'd7
  } cause_e;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_LOAD = 4'b0010,
    BK_DIV  = 4'b0100,
    BK_OUT  = 4'b1000
  } bk_state_e;

  typedef struct packed {
    cmd_e        kind;
    logic [23:0] image_size;
    logic [31:0] expected_crc;
    logic        battery_ok;
    logic [7:0]  data_byte;
    logic [15:0] chunk_size;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic last_op;
  } div_stat_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

[sv/fiv_front.sv]
// Front end: two-word input queue that decodes the request type.
module fiv_front import fiv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [23:0] image_size_i,
  input  logic [31:0] expected_crc_i,
  input  logic        battery_ok_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] chunk_size_i,
  input  logic        last_of_chunk_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in = '{kind: cmd_e'(req_type_i), image_size: image_size_i,
               expected_crc: expected_crc_i, battery_ok: battery_ok_i,
               data_byte: data_byte_i, chunk_size: chunk_size_i,
               last: last_of_chunk_i};
  end

  assign full        = cnt_q[1];
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[sv/fiv_pctdiv.sv]
// Restoring divider for progress percent, one quotient bit per cycle.
module fiv_pctdiv import fiv_pkg::*; #(
  parameter int unsigned TB_W  = 24,
  parameter int unsigned RCV_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RCV_W-1:0] num_i,
  input  logic [TB_W-1:0]  den_i,
  output div_stat_t        stat_o,
  output logic [6:0]       pct_o
);

  localparam int unsigned NW = RCV_W + 7;
  localparam logic [2:0] STEP_OV = 3'd7;

  logic [NW-1:0]   rem_q, num100, dsh;
  logic [TB_W-1:0] den_q;
  logic [6:0]      q_q, q_nx, bit_m, pct_q;
  logic [2:0]      step_q;
  logic            run_q, done_q, ge;

  assign num100 = (NW'(num_i) << 6) + (NW'(num_i) << 5) + (NW'(num_i) << 2);
  assign dsh    = NW'(den_q) << step_q;
  assign ge     = rem_q >= dsh;
  assign bit_m  = 7'd1 << step_q;
  assign q_nx   = ge ? (q_q | bit_m) : q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num100;
      den_q <= den_i;
      q_q   <= 7'd0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh;
      end
      q_q <= q_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_OV;
      pct_q  <= 7'd0;
    end else if (start_i) begin
      step_q <= STEP_OV;
      if (den_i == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
        pct_q  <= 7'd0;
      end else begin
        run_q  <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (run_q) begin
      if (step_q == STEP_OV && ge) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
        pct_q  <= PCT_MAX;
      end else if (step_q == 3'd0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
        pct_q  <= (q_nx > PCT_MAX) ? PCT_MAX : q_nx;
      end
      step_q <= step_q - 3'd1;
    end
  end

  assign stat_o.valid   = done_q;
  assign stat_o.last_op = run_q && (step_q == 3'd0);
  assign pct_o          = pct_q;

endmodule

[sv/fiv_back.sv]
// Back end: download state, CRC update, chunk checks and the result register.
module fiv_back import fiv_pkg::*; #(
  parameter int unsigned TB_W  = 24,
  parameter int unsigned RCV_W = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status_o,
  output logic [2:0]        event_res_o,
  output logic [2:0]        error_cause_o,
  output logic [6:0]        progress_percent_o,
  output logic [31:0]       running_crc_o
);

  bk_state_e        st_q, st_d;
  status_e          phase_q, phase_d;
  event_e           ev_q, ev_d;
  cause_e           cause_q, cause_d;
  logic [TB_W-1:0]  total_q, total_d;
  logic [RCV_W-1:0] rcv_q, rcv_d, rcv_sum;
  logic [31:0]      target_q, target_d, crc_q, crc_d, crc_nx;
  logic [CNT_W-1:0] chunk_q, chunk_d, chunk_inc, idle_q, idle_d;
  logic [23:0]      part_q;
  logic [15:0]      tmo_q;
  logic             exec;
  div_stat_t        div_stat;
  logic [6:0]       pct;

  assign cmd_ready_o = st_q == BK_IDLE;
  assign exec        = cmd_ready_o && cmd_valid_i;
  assign crc_nx      = crc32_byte(crc_q, cmd_i.data_byte);
  assign chunk_inc   = (chunk_q != CNT_MAX) ? chunk_q + 1'b1 : chunk_q;
  assign rcv_sum     = rcv_q + RCV_W'(chunk_inc);

  always_comb begin
    phase_d  = phase_q;
    total_d  = total_q;
    rcv_d    = rcv_q;
    target_d = target_q;
    crc_d    = crc_q;
    chunk_d  = chunk_q;
    idle_d   = idle_q;
    ev_d     = ev_q;
    cause_d  = cause_q;
    if (exec) begin
      ev_d    = EV_NONE;
      cause_d = CS_NONE;
      unique case (cmd_i.kind)
        CMD_START: begin
          if (phase_q == ST_DOWN) begin
            ev_d = EV_REJECTED; cause_d = CS_BUSY;
          end else if (!cmd_i.battery_ok) begin
            ev_d = EV_REJECTED; cause_d = CS_BATTERY;
          end else if (cmd_i.image_size[TB_W-1:0] > part_q[TB_W-1:0]) begin
            ev_d = EV_REJECTED; cause_d = CS_TOO_BIG;
          end else begin
            ev_d     = EV_STARTED;
            phase_d  = ST_DOWN;
            total_d  = cmd_i.image_size[TB_W-1:0];
            target_d = cmd_i.expected_crc;
            rcv_d    = '0;
            crc_d    = CRC_INIT;
            chunk_d  = '0;
            idle_d   = '0;
          end
        end
        CMD_DATA: begin
          if (phase_q != ST_DOWN) begin
            ev_d = EV_REJECTED; cause_d = CS_NOT_DOWN;
          end else begin
            crc_d   = crc_nx;
            chunk_d = chunk_inc;
            if (cmd_i.last) begin
              chunk_d = '0;
              if (idle_q > CNT_W'(tmo_q)) begin
                phase_d = ST_ERR; total_d = '0; rcv_d = '0;
                ev_d = EV_ABORTED; cause_d = CS_TIMEOUT;
              end else if (chunk_inc != CNT_W'(cmd_i.chunk_size)) begin
                phase_d = ST_ERR; total_d = '0; rcv_d = '0;
                ev_d = EV_ABORTED; cause_d = CS_SIZE;
              end else begin
                rcv_d  = rcv_sum;
                idle_d = '0;
                ev_d   = EV_CHUNK_OK;
                if (rcv_sum >= RCV_W'(total_q)) begin
                  if (~crc_nx != target_q) begin
                    phase_d = ST_ERR; total_d = '0; rcv_d = '0;
                    ev_d = EV_ABORTED; cause_d = CS_CRC;
                  end else begin
                    phase_d = ST_DONE;
                    ev_d    = EV_COMPLETE;
                  end
                end
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase_q == ST_DOWN && idle_q != CNT_MAX) begin
            idle_d = idle_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (exec) st_d = BK_LOAD;
      BK_LOAD: st_d = BK_DIV;
      BK_DIV:  if (div_stat.valid) st_d = BK_OUT;
      BK_OUT:  if (pop) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_IDLE;
      phase_q  <= ST_IDLE;
      total_q  <= '0;
      rcv_q    <= '0;
      target_q <= '0;
      crc_q    <= CRC_INIT;
      chunk_q  <= '0;
      idle_q   <= '0;
      ev_q     <= EV_NONE;
      cause_q  <= CS_NONE;
      part_q   <= PART_RST;
      tmo_q    <= TMO_RST;
    end else begin
      st_q     <= st_d;
      phase_q  <= phase_d;
      total_q  <= total_d;
      rcv_q    <= rcv_d;
      target_q <= target_d;
      crc_q    <= crc_d;
      chunk_q  <= chunk_d;
      idle_q   <= idle_d;
      ev_q     <= ev_d;
      cause_q  <= cause_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PARTITION: part_q <= cfg_wdata_i[23:0];
          CFG_TIMEOUT:   tmo_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  fiv_pctdiv #(
    .TB_W  (TB_W),
    .RCV_W (RCV_W)
  ) u_pctdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(st_q == BK_LOAD),
    .num_i  (rcv_q),
    .den_i  (total_q),
    .stat_o (div_stat),
    .pct_o  (pct)
  );

  assign empty              = st_q != BK_OUT;
  assign status_o           = phase_q;
  assign event_res_o        = ev_q;
  assign error_cause_o      = cause_q;
  assign progress_percent_o = pct;
  assign running_crc_o      = ~crc_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pct <= PCT_MAX)
    else $error("progress above 100");

  a_cause_only_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ev_q != EV_REJECTED && ev_q != EV_ABORTED) |-> cause_q == CS_NONE)
    else $error("error cause without reject or abort");

  a_err_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_ERR |-> (total_q == '0 && rcv_q == '0))
    else $error("counts kept after abort");

  a_chunk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != ST_DOWN |-> chunk_q == '0)
    else $error("chunk count outside download");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_DIV && div_stat.last_op) |=> div_stat.valid)
    else $error("divider finished without done");

endmodule

[sv/firmware_image_receive_verifier.sv]
// Firmware image receive verifier: CRC-32 check, chunk and timeout tracking, progress.
// Each word (start, data byte, ms tick, no-op) gives exactly one result word. A two-word
// input queue feeds the executing stage; a word is executed, then the
// progress percent comes out of an eight-step restoring divider, which is skipped when the
// image size after the word is zero; the result then waits for pop. The next word starts
// the cycle after the pop; the input stalls once the queue holds two words.
module firmware_image_receive_verifier import fiv_pkg::*; #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type_i,
  input  logic [23:0]       image_size_i,
  input  logic [31:0]       expected_crc_i,
  input  logic              battery_ok_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       chunk_size_i,
  input  logic              last_of_chunk_i,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status_o,
  output logic [2:0]        event_res_o,
  output logic [2:0]        error_cause_o,
  output logic [6:0]        progress_percent_o,
  output logic [31:0]       running_crc_o
);

  localparam int unsigned TB_W  = (SIZE_BITS < IMG_W) ? SIZE_BITS : IMG_W;
  localparam int unsigned RCV_W = TB_W + 1;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  fiv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .image_size_i   (image_size_i),
    .expected_crc_i (expected_crc_i),
    .battery_ok_i   (battery_ok_i),
    .data_byte_i    (data_byte_i),
    .chunk_size_i   (chunk_size_i),
    .last_of_chunk_i(last_of_chunk_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_ready_i    (cmd_ready)
  );

  fiv_back #(
    .TB_W  (TB_W),
    .RCV_W (RCV_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_ready_o       (cmd_ready),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .event_res_o       (event_res_o),
    .error_cause_o     (error_cause_o),
    .progress_percent_o(progress_percent_o),
    .running_crc_o     (running_crc_o)
  );

endmodule

[verif/firmware_image_receive_verifier_tb.sv]
// Self-checking testbench: directed and random download words scored against a behavioral predictor.
module firmware_image_receive_verifier_tb;
  import fiv_pkg::*;

  typedef struct packed {
    status_e     status;
    event_e      ev;
    cause_e      cause;
    logic [6:0]  pct;
    logic [31:0] crc;
  } result_t;

  typedef struct {
    cmd_t    w;
    bit      typed;
    result_t r;
  } row_t;

  localparam result_t IDLE_QUIET = '{ST_IDLE, EV_NONE, CS_NONE, 7'd0, 32'd0};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic             push;
  logic             full;
  logic             empty;
  logic             pop;
  cmd_t             drv;
  logic [1:0]       res_status;
  logic [2:0]       res_event;
  logic [2:0]       res_cause;
  logic [6:0]       res_pct;
  logic [31:0]      res_crc;

  // predictor state
  status_e     phase_q;
  logic [23:0] total_q;
  logic [24:0] recv_q;
  logic [31:0] target_q;
  logic [31:0] crc_q;
  logic [16:0] chunk_cnt_q;
  logic [16:0] idle_ms_q;
  logic [23:0] part_q;
  logic [15:0] tmo_q;

  result_t     awaited_results[$];
  row_t        dir_rows[$];
  int unsigned mismatch_cnt;
  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_req;

  always #5 clk = ~clk;

  firmware_image_receive_verifier u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .push              (push),
    .full              (full),
    .req_type_i        (drv.kind),
    .image_size_i      (drv.image_size),
    .expected_crc_i    (drv.expected_crc),
    .battery_ok_i      (drv.battery_ok),
    .data_byte_i       (drv.data_byte),
    .chunk_size_i      (drv.chunk_size),
    .last_of_chunk_i   (drv.last),
    .empty             (empty),
    .pop               (pop),
    .status_o          (res_status),
    .event_res_o       (res_event),
    .error_cause_o     (res_cause),
    .progress_percent_o(res_pct),
    .running_crc_o     (res_crc)
  );

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [6:0] percent_of(input logic [24:0] got, input logic [23:0] total);
    longint unsigned p;
    if (total == 0) return 7'd0;
    p = 64'(got) * 100 / 64'(total);
    return (p > 100) ? PCT_MAX : 7'(p);
  endfunction

  task automatic track_download(input cmd_t w, output result_t r);
    logic [16:0] cnt;
    bit          abort;
    cause_e      why;
    abort   = 1'b0;
    why     = CS_NONE;
    r.ev    = EV_NONE;
    r.cause = CS_NONE;
    case (w.kind)
      CMD_START: begin
        if (phase_q == ST_DOWN) begin
          r.ev = EV_REJECTED; r.cause = CS_BUSY;
        end else if (!w.battery_ok) begin
          r.ev = EV_REJECTED; r.cause = CS_BATTERY;
        end else if (w.image_size > part_q) begin
          r.ev = EV_REJECTED; r.cause = CS_TOO_BIG;
        end else begin
          r.ev        = EV_STARTED;
          phase_q     = ST_DOWN;
          total_q     = w.image_size;
          target_q    = w.expected_crc;
          recv_q      = '0;
          crc_q       = CRC_INIT;
          chunk_cnt_q = '0;
          idle_ms_q   = '0;
        end
      end
      CMD_DATA: begin
        if (phase_q != ST_DOWN) begin
          r.ev = EV_REJECTED; r.cause = CS_NOT_DOWN;
        end else begin
          crc_q = crc_next(crc_q, w.data_byte);
          if (chunk_cnt_q != CNT_MAX) chunk_cnt_q++;
          if (w.last) begin
            cnt         = chunk_cnt_q;
            chunk_cnt_q = '0;
            if (idle_ms_q > tmo_q) begin
              abort = 1'b1; why = CS_TIMEOUT;
            end else if (cnt != {1'b0, w.chunk_size}) begin
              abort = 1'b1; why = CS_SIZE;
            end else begin
              recv_q    = recv_q + cnt;
              idle_ms_q = '0;
              if (recv_q >= total_q) begin
                if (~crc_q != target_q) begin
                  abort = 1'b1; why = CS_CRC;
                end else begin
                  phase_q = ST_DONE; r.ev = EV_COMPLETE;
                end
              end else begin
                r.ev = EV_CHUNK_OK;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        if (phase_q == ST_DOWN && idle_ms_q != CNT_MAX) idle_ms_q++;
      end
      default: ;
    endcase
    if (abort) begin
      phase_q = ST_ERR;
      total_q = '0;
      recv_q  = '0;
      r.ev    = EV_ABORTED;
      r.cause = why;
    end
    r.status = phase_q;
    r.pct    = percent_of(recv_q, total_q);
    r.crc    = ~crc_q;
  endtask

  function automatic cmd_t scramble_word();
    cmd_t w;
    w.kind         = cmd_e'($urandom_range(3));
    w.image_size   = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(0, 60));
    w.expected_crc = $urandom;
    w.battery_ok   = 1'($urandom_range(1));
    w.data_byte    = 8'($urandom);
    w.chunk_size   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 10));
    w.last         = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic void add_row(input cmd_t w, input bit typed, input result_t r);
    row_t row;
    row.w     = w;
    row.typed = typed;
    row.r     = r;
    dir_rows.push_back(row);
  endfunction

  task automatic send_word(input cmd_t w, input bit typed = 1'b0, input result_t typed_r = '0);
    result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    drv  <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    track_download(w, r);
    awaited_results.push_back(typed ? typed_r : r);
    words_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_PARTITION) part_q = val[23:0];
    else tmo_q = val[15:0];
  endtask

  task automatic settle_block();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one download: start, then chunks of bytes with ticks and the odd no-op between
  task automatic send_image();
    logic [7:0]  img[$];
    int unsigned lens[$];
    int unsigned n, m, pos, len, got, idx;
    logic [31:0] c;
    logic [31:0] ecrc;
    cmd_t        w;
    n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
    case ($urandom_range(9))
      0:       m = n + $urandom_range(1, 3);
      1:       m = $urandom_range(0, n);
      default: m = n;
    endcase
    if (n == 0) m = $urandom_range(1, 3);
    repeat (m) img.push_back(8'($urandom));
    pos = 0;
    while (pos < m) begin
      len = $urandom_range(1, (m - pos < 8) ? m - pos : 8);
      lens.push_back(len);
      pos += len;
    end
    c   = CRC_INIT;
    got = 0;
    idx = 0;
    foreach (lens[k]) begin
      repeat (lens[k]) begin
        c = crc_next(c, img[idx]);
        idx++;
      end
      got += lens[k];
      if (got >= n) break;
    end
    ecrc           = ($urandom_range(6) == 0) ? $urandom : ~c;
    w              = scramble_word();
    w.kind         = CMD_START;
    w.image_size   = 24'(n);
    w.expected_crc = ecrc;
    w.battery_ok   = ($urandom_range(19) != 0);
    send_word(w);
    idx = 0;
    foreach (lens[k]) begin
      repeat (($urandom_range(9) == 0) ? $urandom_range(2, 8) : $urandom_range(0, 1)) begin
        w      = scramble_word();
        w.kind = CMD_TICK;
        send_word(w);
      end
      for (int j = 0; j < lens[k]; j++) begin
        if ($urandom_range(19) == 0) begin
          w      = scramble_word();
          w.kind = CMD_NOP;
          send_word(w);
        end
        w           = scramble_word();
        w.kind      = CMD_DATA;
        w.data_byte = img[idx];
        w.last      = (j == lens[k] - 1);
        idx++;
        if (w.last) begin
          case ($urandom_range(9))
            0:       ;
            1:       w.chunk_size = 16'(lens[k] + 1);
            default: w.chunk_size = 16'(lens[k]);
          endcase
        end
        send_word(w);
      end
    end
  endtask

  initial begin : result_side
    int unsigned hold_left;
    result_t     act;
    result_t     want;
    bit          bad;
    hold_left = 0;
    pop       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        act = '{status_e'(res_status), event_e'(res_event), cause_e'(res_cause), res_pct, res_crc};
        if (awaited_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: st=%0d ev=%0d cs=%0d pct=%0d crc=%08h",
                     act.status, act.ev, act.cause, act.pct, act.crc);
        end else begin
          want = awaited_results.pop_front();
          bad  = (act.status !== want.status) || (act.ev !== want.ev) ||
                 (act.cause !== want.cause) || (act.pct !== want.pct) ||
                 (act.crc !== want.crc);
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch st/ev/cs/pct/crc: exp %0d/%0d/%0d/%0d/%08h got %0d/%0d/%0d/%0d/%08h",
                       want.status, want.ev, want.cause, want.pct, want.crc,
                       act.status, act.ev, act.cause, act.pct, act.crc);
          end
        end
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] crc_zero;
    logic [31:0] crc_abc;
    int unsigned base;
    cmd_t        w;
    rst_n         = 1'b0;
    push          = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_PARTITION;
    cfg_wdata     = '0;
    drv           = '0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_req      = 1'b0;
    mismatch_cnt  = 0;
    words_sent    = 0;
    part_q        = PART_RST;
    tmo_q         = TMO_RST;
    phase_q       = ST_IDLE;
    total_q       = '0;
    recv_q        = '0;
    target_q      = '0;
    crc_q         = CRC_INIT;
    chunk_cnt_q   = '0;
    idle_ms_q     = '0;

    crc_zero = ~crc_next(CRC_INIT, 8'h00);
    crc_abc  = ~crc_next(crc_next(crc_next(CRC_INIT, 8'h31), 8'h32), 8'h33);

    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_IDLE, EV_REJECTED, CS_NOT_DOWN, 7'd0, 32'd0});
    add_row('{CMD_TICK, 24'd0, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b1, IDLE_QUIET);
    add_row('{CMD_NOP, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'hFF, 16'hFFFF, 1'b1}, 1'b1, IDLE_QUIET);
    add_row('{CMD_START, 24'd5, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_IDLE, EV_REJECTED, CS_BATTERY, 7'd0, 32'd0});
    add_row('{CMD_START, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_STARTED, CS_NONE, 7'd0, 32'd0});
    add_row('{CMD_START, 24'd0, 32'd0, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_REJECTED, CS_BUSY, 7'd0, 32'd0});
    add_row('{CMD_TICK, 24'd0, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_NONE, CS_NONE, 7'd0, 32'd0});
    // chunk length mismatch
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'hFF, 16'hFFFF, 1'b1}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_START, 24'd0, 32'd0, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_STARTED, CS_NONE, 7'd0, 32'd0});
    // crc mismatch
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h00, 16'd1, 1'b1}, 1'b0, '0);
    add_row('{CMD_START, 24'd1, crc_zero, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_STARTED, CS_NONE, 7'd0, 32'd0});
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h00, 16'd1, 1'b1}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h55, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_START, 24'd3, crc_abc, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_STARTED, CS_NONE, 7'd0, 32'd0});
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h31, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h32, 16'd2, 1'b1}, 1'b0, '0);
    add_row('{CMD_TICK, 24'd0, 32'd0, 1'b0, 8'h00, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h33, 16'd1, 1'b1}, 1'b0, '0);
    // more bytes than the image: progress saturates
    add_row('{CMD_START, 24'd2, crc_abc, 1'b1, 8'h00, 16'd0, 1'b0}, 1'b1,
            '{ST_DOWN, EV_STARTED, CS_NONE, 7'd0, 32'd0});
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h31, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h32, 16'd0, 1'b0}, 1'b0, '0);
    add_row('{CMD_DATA, 24'd0, 32'd0, 1'b0, 8'h33, 16'd3, 1'b1}, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

    for (int ph = 0; ph < 6; ph++) begin
      settle_block();
      case (ph)
        0: begin
          write_reg(CFG_PARTITION, 24'hFFFFFF);
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'hFFFF});
          send_idle_pct = 0;  rx_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_PARTITION, 24'd0);
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'd1});
          send_idle_pct = 84; rx_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_PARTITION, 24'($urandom_range(16, 200)));
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'($urandom_range(1, 6))});
          send_idle_pct = 0;  rx_stall_pct = 84;
        end
        3: begin
          write_reg(CFG_PARTITION, 24'($urandom));
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'd2});
          send_idle_pct = 8;  rx_stall_pct = 8;
        end
        4: begin
          write_reg(CFG_PARTITION, 24'd48);
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'd3});
          send_idle_pct = 0;  rx_stall_pct = 0;
          hold_req      = 1'b1;
        end
        default: begin
          write_reg(CFG_PARTITION, 24'hFFFFFF);
          write_reg(CFG_TIMEOUT, {8'($urandom), 16'($urandom_range(1, 4))});
          send_idle_pct = 84; rx_stall_pct = 0;
        end
      endcase
      cfg_we <= 1'b0;
      base = words_sent;
      while (words_sent - base < 120) begin
        if ($urandom_range(99) < 70) begin
          send_image();
        end else begin
          w = scramble_word();
          if (w.kind == CMD_START && $urandom_range(1))
            w.image_size = part_q + 24'($urandom_range(0, 1));
          send_word(w);
        end
      end
    end

    rx_stall_pct = 0;
    settle_block();
    repeat (30) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
